// ----- src/sprite_slot_cache_assert.svh -----
// assertion macros for the sprite slot cache checks
`ifndef SPRITE_SLOT_CACHE_ASSERT_SVH
`define SPRITE_SLOT_CACHE_ASSERT_SVH

// same-cycle implication
`define SSC_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sprite slot cache check failed");

// next-cycle implication
`define SSC_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sprite slot cache check failed");

`endif

// ----- src/ssc_pkg.sv -----
// shared types and constants for the sprite slot cache
package ssc_pkg;

	localparam int SLOTS_DEF  = 64;
	localparam int SPRITES_DEF = 256;
	localparam int ID_W       = 8;
	localparam int SLOT_OUT_W = 6;
	localparam int CFG_W      = 6;
	localparam int TEMP_RST   = 3;
	localparam int VAR_W      = 2;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_TEMP_SLOTS = '0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LK_CHK,
		ST_SR_CHK,
		ST_RT_CHK,
		ST_CUT_CHK,
		ST_RT_WR,
		ST_EMIT
	} ssc_state_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            flip;
		logic            flash;
	} ssc_req_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
		logic load_needed;
	} ssc_status_t;

endpackage

// ----- src/ssc_engine.sv -----
// sequencer with link table and slot tag memories
module ssc_engine #(
	parameter int SLOTS = ssc_pkg::SLOTS_DEF,
	parameter int SPRITES = ssc_pkg::SPRITES_DEF,
	localparam int SW = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ssc_pkg::ssc_req_t     req,
	input  logic [SW-1:0]         temp_t,
	input  logic                  res_ready,
	output ssc_pkg::ssc_status_t  status,
	output logic [SW-1:0]         res_slot
);
	import ssc_pkg::*;

	localparam int LDEPTH = 2 * SPRITES;
	localparam int LW = $clog2(LDEPTH);
	localparam int LNK_W = SW + 1;
	localparam int TAG_W = ID_W + VAR_W;
	localparam int RST_T = (TEMP_RST > SLOTS - 1) ? SLOTS - 1 : TEMP_RST;
	localparam int NPTR_RST = SLOTS - 1 - RST_T;

	ssc_state_t state_q, state_d;
	ssc_req_t req_q;
	logic [SW-1:0] scan_q, victim_q, nptr_q, tptr_q, res_slot_q;
	logic res_load_q;
	logic [SLOTS-1:0] used_q;
	logic [LW-1:0] clr_q, old_li_q;

	logic [LNK_W-1:0] link_mem [LDEPTH];
	logic [LNK_W-1:0] link_rd_q;
	logic [TAG_W-1:0] tag_mem [SLOTS];
	logic [TAG_W-1:0] tag_rd_q;

	logic [SW-1:0] base_w, nptr_next, tptr_next, tag_raddr;
	logic [SW:0] nptr_inc, tptr_inc;
	logic [SW+1:0] n_sum;
	logic [LW-1:0] li_in, li_q, old_li_w, link_raddr, link_waddr;
	logic [LNK_W-1:0] link_wdata;
	logic link_we, scan_last, srch_hit, link_hit, cut_hit;

	assign base_w = SW'((SW+1)'(SLOTS) - {1'b0, temp_t});
	assign li_in = LW'({req.id, req.flip});
	assign li_q = LW'({req_q.id, req_q.flip});
	assign old_li_w = LW'({tag_rd_q[TAG_W-1:VAR_W], tag_rd_q[0]});

	assign nptr_inc = {1'b0, nptr_q} + (SW+1)'(1);
	assign n_sum = {1'b0, nptr_inc} + (SW+2)'(temp_t);
	assign nptr_next = (n_sum >= (SW+2)'(SLOTS)) ? '0 : nptr_inc[SW-1:0];

	assign tptr_inc = {1'b0, tptr_q} + (SW+1)'(1);
	assign tptr_next = (tptr_inc < {1'b0, base_w} || tptr_inc >= (SW+1)'(SLOTS)) ?
		base_w : tptr_inc[SW-1:0];

	assign scan_last = (scan_q == SW'(SLOTS - 1));
	assign srch_hit = used_q[scan_q] && (tag_rd_q == {req_q.id, 1'b1, req_q.flip});
	assign link_hit = link_rd_q[SW];
	assign cut_hit = link_rd_q[SW] && (link_rd_q[SW-1:0] == victim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		link_raddr = li_q;
		tag_raddr = scan_q;
		link_we = 1'b0;
		link_waddr = li_q;
		link_wdata = {1'b1, victim_q};
		case (state_q)
			ST_CLEAR: begin
				link_we = 1'b1;
				link_waddr = clr_q;
				link_wdata = '0;
				if (clr_q == LW'(LDEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				link_raddr = li_in;
				tag_raddr = base_w;
				if (start) state_d = req.flash ? ST_SR_CHK : ST_LK_CHK;
			end
			ST_LK_CHK: begin
				tag_raddr = nptr_next;
				state_d = link_hit ? ST_EMIT : ST_RT_CHK;
			end
			ST_SR_CHK: begin
				tag_raddr = scan_last ? tptr_next : scan_q + SW'(1);
				if (srch_hit) begin
					state_d = ST_EMIT;
				end else if (scan_last) begin
					state_d = ST_RT_CHK;
				end
			end
			ST_RT_CHK: begin
				link_raddr = old_li_w;
				if (used_q[victim_q] && !tag_rd_q[VAR_W-1]) begin
					state_d = ST_CUT_CHK;
				end else begin
					state_d = ST_RT_WR;
				end
			end
			ST_CUT_CHK: begin
				if (cut_hit) begin
					link_we = 1'b1;
					link_waddr = old_li_q;
					link_wdata = '0;
				end
				state_d = ST_RT_WR;
			end
			ST_RT_WR: begin
				if (!req_q.flash) link_we = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nptr_q <= SW'(NPTR_RST);
			tptr_q <= SW'(SLOTS - 1);
			used_q <= '0;
			clr_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + LW'(1);
			if (state_q == ST_LK_CHK && !link_hit) nptr_q <= nptr_next;
			if (state_q == ST_SR_CHK && !srch_hit && scan_last) tptr_q <= tptr_next;
			if (state_q == ST_RT_WR) used_q[victim_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_q <= req;
					scan_q <= base_w;
				end
			end
			ST_LK_CHK: begin
				if (link_hit) begin
					res_slot_q <= link_rd_q[SW-1:0];
					res_load_q <= 1'b0;
				end else begin
					victim_q <= nptr_next;
				end
			end
			ST_SR_CHK: begin
				if (srch_hit) begin
					res_slot_q <= scan_q;
					res_load_q <= 1'b0;
				end else if (scan_last) begin
					victim_q <= tptr_next;
				end else begin
					scan_q <= scan_q + SW'(1);
				end
			end
			ST_RT_CHK: begin
				old_li_q <= old_li_w;
			end
			ST_RT_WR: begin
				res_slot_q <= victim_q;
				res_load_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_waddr] <= link_wdata;
		link_rd_q <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RT_WR) tag_mem[victim_q] <= {req_q.id, req_q.flash, req_q.flip};
		tag_rd_q <= tag_mem[tag_raddr];
	end

	assign status.idle = (state_q == ST_IDLE);
	assign status.res_valid = (state_q == ST_EMIT);
	assign status.load_needed = res_load_q;
	assign res_slot = res_slot_q;

endmodule

// ----- src/sprite_slot_cache.sv -----
// sprite slot cache top level: config register, request intake and result register
// a normal request is looked up in the link table; a flash request scans the temp region
// slot by slot; on a miss a victim slot is retagged before the result is given
// one request at a time; the next is taken only once the previous result is registered
// after reset the link table is swept, one entry a cycle over all 2*SPRITES entries
// (512 by default), with req_ready low; the config port works throughout
module sprite_slot_cache #(
	parameter int SLOTS = ssc_pkg::SLOTS_DEF,
	parameter int SPRITES = ssc_pkg::SPRITES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ssc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ssc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [ssc_pkg::ID_W-1:0]          sprite_id,
	input  logic                              flipped,
	input  logic                              flash,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [ssc_pkg::SLOT_OUT_W-1:0]    slot,
	output logic                              load_needed
);
	import ssc_pkg::*;

	localparam int SW = $clog2(SLOTS);

	logic [CFG_W-1:0] temp_slots_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [SW-1:0] temp_eff, eng_slot;
	logic [ID_W-1:0] id_red;
	ssc_req_t eng_req;
	ssc_status_t eng_status;
	logic start, eng_res_ready;
	logic res_valid_q, load_q;
	logic [SLOT_OUT_W-1:0] slot_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign prdata = (reg_idx == REG_TEMP_SLOTS) ? APB_DATA_W'(temp_slots_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_slots_q <= CFG_W'(TEMP_RST);
		end else if (psel && penable && pwrite && pready && reg_idx == REG_TEMP_SLOTS) begin
			temp_slots_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		if (temp_slots_q == '0) begin
			temp_eff = SW'(1);
		end else if (32'(temp_slots_q) > SLOTS - 1) begin
			temp_eff = SW'(SLOTS - 1);
		end else begin
			temp_eff = SW'(temp_slots_q);
		end
	end

	// sprite number folded into range by restoring subtraction
	always_comb begin
		id_red = sprite_id;
		for (int k = ID_W - 1; k >= 0; k--) begin
			if ((SPRITES << k) < (1 << ID_W)) begin
				if (id_red >= ID_W'(SPRITES << k)) id_red = id_red - ID_W'(SPRITES << k);
			end
		end
	end

	assign eng_req.id = id_red;
	assign eng_req.flip = flipped;
	assign eng_req.flash = flash;

	assign req_ready = eng_status.idle;
	assign start = req_valid && req_ready;
	assign eng_res_ready = !res_valid_q || res_ready;

	ssc_engine #(
		.SLOTS(SLOTS),
		.SPRITES(SPRITES)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(eng_req),
		.temp_t(temp_eff),
		.res_ready(eng_res_ready),
		.status(eng_status),
		.res_slot(eng_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (eng_status.res_valid && eng_res_ready) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_status.res_valid && eng_res_ready) begin
			slot_q <= SLOT_OUT_W'(eng_slot);
			load_q <= eng_status.load_needed;
		end
	end

	assign res_valid = res_valid_q;
	assign slot = slot_q;
	assign load_needed = load_q;

endmodule

// ----- src/ssc_checker.sv -----
// port-level checks for the sprite slot cache, bound to the top level
`include "sprite_slot_cache_assert.svh"

module ssc_checker #(
	parameter int SLOTS = ssc_pkg::SLOTS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [ssc_pkg::SLOT_OUT_W-1:0] slot,
	input logic                           load_needed
);
	import ssc_pkg::*;

	logic [1:0] pend_q;
	logic req_acc, res_acc;

	assign req_acc = req_valid && req_ready;
	assign res_acc = res_valid && res_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !res_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (!req_acc && res_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`SSC_ASSERT_NOW(a_res_has_req, clk, arst_n, res_valid, pend_q != 2'd0)
	`SSC_ASSERT_NOW(a_one_in_flight, clk, arst_n, pend_q == 2'd2, !req_ready)
	`SSC_ASSERT_NOW(a_slot_range, clk, arst_n, res_valid, 32'(slot) < SLOTS)
	`SSC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(slot) && $stable(load_needed))

endmodule

bind sprite_slot_cache ssc_checker #(
	.SLOTS(SLOTS)
) u_ssc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.slot(slot),
	.load_needed(load_needed)
);

// ----- verif/sprite_slot_cache_test.sv -----
// self-checking testbench for the sprite slot cache: directed table, then random requests
`timescale 1ns / 1ps

module sprite_slot_cache_test;
	import ssc_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam int LINKS = 2 * SPRITES_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 80;
	localparam int CHUNK_REQS = 150;
	localparam logic [VAR_W-1:0] VAR_FLASH = 2'd2;
	localparam logic [APB_ADDR_W-1:0] ADDR_TEMP_SLOTS = {REG_TEMP_SLOTS, 2'b00};

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  load;
	} cache_ans_t;

	typedef struct {
		row_kind_t             kind;
		logic [ID_W-1:0]       id;
		logic                  flip;
		logic                  flash;
		logic [CFG_W-1:0]      cfg_val;
		bit                    fixed;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  load;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  req_valid;
	logic                  req_ready;
	logic [ID_W-1:0]       sprite_id;
	logic                  flipped;
	logic                  flash;
	logic                  res_valid;
	logic                  res_ready;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  load_needed;

	// fixed expectation travelling with the request on offer
	logic                  fx_on;
	logic [SLOT_OUT_W-1:0] fx_slot;
	logic                  fx_load;

	// predictor state
	logic [ID_W-1:0]       slot_tag [SLOTS];
	logic [VAR_W-1:0]      slot_kind [SLOTS];
	bit                    slot_busy [SLOTS] = '{default: 1'b0};
	bit                    link_ok [LINKS] = '{default: 1'b0};
	logic [SLOT_OUT_W-1:0] link_to [LINKS];
	int                    norm_ptr = SLOTS - 1 - TEMP_RST;
	int                    flash_ptr = SLOTS - 1;
	logic [CFG_W-1:0]      cfg_temp = CFG_W'(TEMP_RST);

	cache_ans_t expected_ans[$];
	int n_req_taken = 0;
	int n_ans_seen = 0;
	int n_errors = 0;
	int n_cycles = 0;
	int snd_idle = 0;
	int rcv_idle = 0;
	bit hold_go = 1'b0;

	dir_row_t dir_rows[23] = '{
		'{ROW_REQ, 8'd0,   1'b0, 1'b0, 6'd0,  1'b1, 6'd0,  1'b1},
		'{ROW_REQ, 8'd0,   1'b0, 1'b0, 6'd0,  1'b1, 6'd0,  1'b0},
		'{ROW_REQ, 8'd0,   1'b1, 1'b0, 6'd0,  1'b1, 6'd1,  1'b1},
		'{ROW_REQ, 8'd255, 1'b1, 1'b0, 6'd0,  1'b1, 6'd2,  1'b1},
		'{ROW_REQ, 8'd255, 1'b1, 1'b0, 6'd0,  1'b1, 6'd2,  1'b0},
		'{ROW_REQ, 8'd0,   1'b0, 1'b1, 6'd0,  1'b1, 6'd61, 1'b1},
		'{ROW_REQ, 8'd0,   1'b1, 1'b1, 6'd0,  1'b1, 6'd62, 1'b1},
		'{ROW_REQ, 8'd255, 1'b0, 1'b1, 6'd0,  1'b1, 6'd63, 1'b1},
		'{ROW_REQ, 8'd0,   1'b0, 1'b1, 6'd0,  1'b1, 6'd61, 1'b0},
		'{ROW_REQ, 8'd255, 1'b1, 1'b1, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd0,   1'b1, 1'b0, 6'd0,  1'b1, 6'd1,  1'b0},
		'{ROW_CFG, 8'd0,   1'b0, 1'b0, 6'd63, 1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd1,   1'b0, 1'b0, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd0,   1'b0, 1'b0, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd0,   1'b1, 1'b0, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd170, 1'b0, 1'b1, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd85,  1'b1, 1'b1, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_CFG, 8'd0,   1'b0, 1'b0, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd85,  1'b1, 1'b1, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd200, 1'b0, 1'b0, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd255, 1'b1, 1'b0, 6'd0,  1'b0, 6'd0,  1'b0},
		'{ROW_CFG, 8'd0,   1'b0, 1'b0, 6'd3,  1'b0, 6'd0,  1'b0},
		'{ROW_REQ, 8'd17,  1'b1, 1'b1, 6'd0,  1'b0, 6'd0,  1'b0}
	};

	sprite_slot_cache u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sprite_id(sprite_id),
		.flipped(flipped),
		.flash(flash),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.slot(slot),
		.load_needed(load_needed)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		n_errors++;
	endtask

	function automatic void retag_slot(input int s, input logic [ID_W-1:0] id,
			input logic [VAR_W-1:0] kind);
		logic [8:0] old_link;
		if (slot_busy[s] && slot_kind[s] < VAR_FLASH) begin
			old_link = {slot_tag[s], slot_kind[s][0]};
			if (link_ok[old_link] && link_to[old_link] == SLOT_OUT_W'(s))
				link_ok[old_link] = 1'b0;
		end
		slot_tag[s] = id;
		slot_kind[s] = kind;
		slot_busy[s] = 1'b1;
	endfunction

	function automatic cache_ans_t serve_request(input ssc_req_t r);
		cache_ans_t a;
		int t;
		int base;
		int p;
		bit hit;
		logic [8:0] li;
		t = (cfg_temp == '0) ? 1 : int'(cfg_temp);
		if (t > SLOTS - 1)
			t = SLOTS - 1;
		base = SLOTS - t;
		a = '0;
		hit = 1'b0;
		if (r.flash) begin
			for (int i = base; i < SLOTS; i++)
				if (!hit && slot_busy[i] && slot_tag[i] == r.id &&
						slot_kind[i] == (VAR_FLASH | VAR_W'(r.flip))) begin
					hit = 1'b1;
					a.slot = SLOT_OUT_W'(i);
				end
			if (!hit) begin
				p = flash_ptr + 1;
				if (p < base || p >= SLOTS)
					p = base;
				flash_ptr = p;
				retag_slot(p, r.id, VAR_FLASH | VAR_W'(r.flip));
				a.slot = SLOT_OUT_W'(p);
				a.load = 1'b1;
			end
		end else begin
			li = {r.id, r.flip};
			if (link_ok[li]) begin
				a.slot = link_to[li];
			end else begin
				p = norm_ptr + 1;
				if (p + t >= SLOTS)
					p = 0;
				norm_ptr = p;
				retag_slot(p, r.id, VAR_W'(r.flip));
				link_ok[li] = 1'b1;
				link_to[li] = SLOT_OUT_W'(p);
				a.slot = SLOT_OUT_W'(p);
				a.load = 1'b1;
			end
		end
		return a;
	endfunction

	// request intake and result checking
	always @(posedge clk) begin : watch
		cache_ans_t pred;
		cache_ans_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				pred = serve_request({sprite_id, flipped, flash});
				if (fx_on)
					pred = {fx_slot, fx_load};
				expected_ans.push_back(pred);
			end
			if (res_valid && res_ready) begin
				n_ans_seen++;
				if (expected_ans.size() == 0) begin
					report_mismatch("result with no request waiting, slot", -1, slot);
				end else begin
					want = expected_ans.pop_front();
					if (slot !== want.slot)
						report_mismatch("slot", want.slot, slot);
					if (load_needed !== want.load)
						report_mismatch("load_needed", want.load, load_needed);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("sprite_slot_cache_test failed");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic offer_request(input logic [ID_W-1:0] id, input logic flip, input logic fl,
			input bit fixed, input logic [SLOT_OUT_W-1:0] s, input logic ld);
		if ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		req_valid <= 1'b1;
		sprite_id <= id;
		flipped <= flip;
		flash <= fl;
		fx_on <= fixed;
		fx_slot <= s;
		fx_load <= ld;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		n_req_taken++;
	endtask

	task automatic wait_results_in();
		req_valid <= 1'b0;
		@(posedge clk);
		while (n_ans_seen < n_req_taken) @(posedge clk);
	endtask

	task automatic write_temp_slots(input logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_TEMP_SLOTS;
		pwdata <= {(APB_DATA_W - CFG_W)'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_temp = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== v)
			report_mismatch("temp_slots readback", v, prdata[CFG_W-1:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] cfg_plan [9];
		logic [ID_W-1:0] pool [64];
		logic [ID_W-1:0] id;
		int npool;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		sprite_id = '0;
		flipped = 1'b0;
		flash = 1'b0;
		fx_on = 1'b0;
		fx_slot = '0;
		fx_load = 1'b0;
		cfg_plan = '{6'd1, 6'd63, 6'd5, 6'd0, 6'd32, 6'd62, 6'd0, 6'd2, 6'd0};
		cfg_plan[6] = CFG_W'($urandom_range(63));
		cfg_plan[8] = CFG_W'($urandom_range(63));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				wait_results_in();
				write_temp_slots(dir_rows[k].cfg_val);
			end else begin
				offer_request(dir_rows[k].id, dir_rows[k].flip, dir_rows[k].flash,
					dir_rows[k].fixed, dir_rows[k].slot, dir_rows[k].load);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 28 : (ph == 1) ? 74 : 0;
			rcv_idle = (ph == 0) ? 74 : (ph == 1) ? 28 : 0;
			for (int c = 0; c < 3; c++) begin
				wait_results_in();
				write_temp_slots(cfg_plan[ph * 3 + c]);
				if (ph == 2 && c == 1)
					hold_go = 1'b1;
				npool = $urandom_range(2, 64);
				for (int j = 0; j < npool; j++)
					pool[j] = ID_W'($urandom_range(255));
				for (int n = 0; n < CHUNK_REQS; n++) begin
					if (n == CHUNK_REQS / 2)
						wait_results_in();
					if ($urandom_range(99) < 75)
						id = pool[$urandom_range(npool - 1)];
					else
						id = ID_W'($urandom);
					offer_request(id, 1'($urandom), $urandom_range(99) < 40,
						1'b0, '0, 1'b0);
				end
			end
		end

		wait_results_in();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_ans.size() == 0)
			$display("sprite_slot_cache_test passed");
		else
			$display("sprite_slot_cache_test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/ssc_pkg.sv
src/ssc_engine.sv
src/sprite_slot_cache.sv
src/ssc_checker.sv
verif/sprite_slot_cache_test.sv
